// ===== hdl/siu_pkg.sv =====
// ============================================================================
// siu_pkg
// Shared types and constants for the segment intersection unit.
// ============================================================================
package siu_pkg;

    localparam int OUT_W = 33;

    typedef enum logic [2:0] {
        HC_NONE  = 3'd0,
        HC_CROSS = 3'd1,
        HC_AT_C  = 3'd2,
        HC_AT_D  = 3'd3,
        HC_AT_A  = 3'd4,
        HC_AT_B  = 3'd5
    } hit_case_t;

    typedef enum logic [1:0] {
        OR_COL = 2'd0,
        OR_POS = 2'd1,
        OR_NEG = 2'd2
    } orient_t;

    function automatic orient_t orient_code(logic zero, logic neg);
        orient_t o;
        if (zero) begin
            o = OR_COL;
        end else if (neg) begin
            o = OR_NEG;
        end else begin
            o = OR_POS;
        end
        return o;
    endfunction

endpackage

// ===== hdl/segment_intersection_unit.sv =====
// ============================================================================
// segment_intersection_unit
// Two-segment intersection test with fixed-point crossing point.
// ============================================================================
// Throughput: one word per cycle while the output is not stalled (m_valid held with
// m_ready low); the divider retires one quotient bit per stage over
// COORD_BITS + FRAC_BITS + 2 stages.
// Reset clears the valid bits of every stage and the output valid register.
module segment_intersection_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [COORD_BITS-1:0]       s_a_x,
    input  logic signed [COORD_BITS-1:0]       s_a_y,
    input  logic signed [COORD_BITS-1:0]       s_b_x,
    input  logic signed [COORD_BITS-1:0]       s_b_y,
    input  logic signed [COORD_BITS-1:0]       s_c_x,
    input  logic signed [COORD_BITS-1:0]       s_c_y,
    input  logic signed [COORD_BITS-1:0]       s_d_x,
    input  logic signed [COORD_BITS-1:0]       s_d_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic [2:0]                         m_hit_case,
    output logic signed [siu_pkg::OUT_W-1:0]   m_cross_x,
    output logic signed [siu_pkg::OUT_W-1:0]   m_cross_y
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DFW  = C + 1;
    localparam int PW   = 2 * C + 2;
    localparam int VW   = 2 * C + 3;
    localparam int DW   = 2 * C + 2;
    localparam int MW1  = C + VW;
    localparam int MW2  = DFW + VW;
    localparam int NSW  = MW2 + 1;
    localparam int NW   = NSW + F + 1;
    localparam int QW   = C + F + 2;
    localparam int EW   = QW + 1;
    localparam int CW   = 8 * C;
    localparam int SBW  = CW + 8;
    localparam int PIPE = QW + 6;
    localparam logic [EW-1:0] HALF = (EW'(1) << F) >> 1;

    logic en;
    logic vld_reg [PIPE];
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < PIPE; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ---- stage 1: differences
    logic [CW-1:0]          crd1_reg;
    logic signed [DFW-1:0]  ux1_reg, uy1_reg, vx1_reg, vy1_reg;
    logic signed [DFW-1:0]  acx1_reg, acy1_reg, adx1_reg, ady1_reg, cbx1_reg, cby1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            crd1_reg <= {s_a_x, s_a_y, s_b_x, s_b_y, s_c_x, s_c_y, s_d_x, s_d_y};
            ux1_reg  <= DFW'(s_b_x) - DFW'(s_a_x);
            uy1_reg  <= DFW'(s_b_y) - DFW'(s_a_y);
            vx1_reg  <= DFW'(s_d_x) - DFW'(s_c_x);
            vy1_reg  <= DFW'(s_d_y) - DFW'(s_c_y);
            acx1_reg <= DFW'(s_c_x) - DFW'(s_a_x);
            acy1_reg <= DFW'(s_c_y) - DFW'(s_a_y);
            adx1_reg <= DFW'(s_d_x) - DFW'(s_a_x);
            ady1_reg <= DFW'(s_d_y) - DFW'(s_a_y);
            cbx1_reg <= DFW'(s_b_x) - DFW'(s_c_x);
            cby1_reg <= DFW'(s_b_y) - DFW'(s_c_y);
        end
    end

    // ---- stage 2: cross products
    logic [CW-1:0]         crd2_reg;
    logic signed [DFW-1:0] ux2_reg, uy2_reg;
    logic signed [PW-1:0]  p1a_reg, p1b_reg, p2a_reg, p2b_reg, p3a_reg, p3b_reg;
    logic signed [PW-1:0]  p4a_reg, p4b_reg, pda_reg, pdb_reg, pta_reg, ptb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            crd2_reg <= crd1_reg;
            ux2_reg  <= ux1_reg;
            uy2_reg  <= uy1_reg;
            p1a_reg  <= PW'(ux1_reg * acy1_reg);
            p1b_reg  <= PW'(uy1_reg * acx1_reg);
            p2a_reg  <= PW'(ux1_reg * ady1_reg);
            p2b_reg  <= PW'(uy1_reg * adx1_reg);
            p3a_reg  <= PW'(vy1_reg * acx1_reg);
            p3b_reg  <= PW'(vx1_reg * acy1_reg);
            p4a_reg  <= PW'(vx1_reg * cby1_reg);
            p4b_reg  <= PW'(vy1_reg * cbx1_reg);
            pda_reg  <= PW'(ux1_reg * vy1_reg);
            pdb_reg  <= PW'(uy1_reg * vx1_reg);
            pta_reg  <= PW'(acx1_reg * vy1_reg);
            ptb_reg  <= PW'(acy1_reg * vx1_reg);
        end
    end

    // ---- stage 3: orientations, determinant
    logic signed [VW-1:0] v1_next, v2_next, v3_next, v4_next, den_next, tn_next;
    siu_pkg::orient_t     o1, o2, o3, o4;
    logic [5:0]           flg_next;
    logic [CW-1:0]        crd3_reg;
    logic signed [DFW-1:0] ux3_reg, uy3_reg;
    logic signed [VW-1:0] den3_reg, tn3_reg;
    logic [5:0]           flg3_reg;

    always_comb begin
        v1_next  = VW'(p1a_reg) - VW'(p1b_reg);
        v2_next  = VW'(p2a_reg) - VW'(p2b_reg);
        v3_next  = VW'(p3a_reg) - VW'(p3b_reg);
        v4_next  = VW'(p4a_reg) - VW'(p4b_reg);
        den_next = VW'(pda_reg) - VW'(pdb_reg);
        tn_next  = VW'(pta_reg) - VW'(ptb_reg);
        o1 = siu_pkg::orient_code(v1_next == '0, v1_next[VW-1]);
        o2 = siu_pkg::orient_code(v2_next == '0, v2_next[VW-1]);
        o3 = siu_pkg::orient_code(v3_next == '0, v3_next[VW-1]);
        o4 = siu_pkg::orient_code(v4_next == '0, v4_next[VW-1]);
        // flags: crossing branch, zero determinant, collinear C, D, A, B
        flg_next = {(o1 != o2) && (o3 != o4), den_next == '0,
                    o1 == siu_pkg::OR_COL, o2 == siu_pkg::OR_COL,
                    o3 == siu_pkg::OR_COL, o4 == siu_pkg::OR_COL};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            crd3_reg <= crd2_reg;
            ux3_reg  <= ux2_reg;
            uy3_reg  <= uy2_reg;
            den3_reg <= den_next[VW-1] ? -den_next : den_next;
            tn3_reg  <= den_next[VW-1] ? -tn_next : tn_next;
            flg3_reg <= flg_next;
        end
    end

    // ---- stage 4: numerator products
    logic [CW-1:0]        crd4_reg;
    logic [5:0]           flg4_reg;
    logic [DW-1:0]        den4_reg;
    logic signed [MW1-1:0] mbx_reg, mby_reg;
    logic signed [MW2-1:0] mtx_reg, mty_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            crd4_reg <= crd3_reg;
            flg4_reg <= flg3_reg;
            den4_reg <= den3_reg[DW-1:0];
            mbx_reg  <= MW1'($signed(crd3_reg[CW-1 -: C]) * den3_reg);
            mby_reg  <= MW1'($signed(crd3_reg[CW-C-1 -: C]) * den3_reg);
            mtx_reg  <= MW2'(ux3_reg * tn3_reg);
            mty_reg  <= MW2'(uy3_reg * tn3_reg);
        end
    end

    // ---- stage 5: numerator magnitude, scaled, with rounding offset
    logic signed [NSW-1:0] sx_next, sy_next;
    logic [NSW-1:0]        magx_next, magy_next;
    logic [NW-1:0]         numx5_reg, numy5_reg;
    logic [DW-1:0]         den5_reg;
    logic [SBW-1:0]        sb5_reg;

    always_comb begin
        sx_next   = NSW'(mbx_reg) + NSW'(mtx_reg);
        sy_next   = NSW'(mby_reg) + NSW'(mty_reg);
        magx_next = sx_next[NSW-1] ? NSW'(-sx_next) : NSW'(sx_next);
        magy_next = sy_next[NSW-1] ? NSW'(-sy_next) : NSW'(sy_next);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            numx5_reg <= (NW'(magx_next) << F) + NW'(den4_reg >> 1);
            numy5_reg <= (NW'(magy_next) << F) + NW'(den4_reg >> 1);
            den5_reg  <= den4_reg;
            sb5_reg   <= {crd4_reg, flg4_reg, sx_next[NSW-1], sy_next[NSW-1]};
        end
    end

    // ---- divider lanes with side band
    logic [QW-1:0]  qx, qy;
    logic [SBW-1:0] sb_reg [QW];

    siu_div_lane #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
        .aclk  (aclk),
        .en    (en),
        .num_i (numx5_reg),
        .den_i (den5_reg),
        .quo_o (qx)
    );

    siu_div_lane #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
        .aclk  (aclk),
        .en    (en),
        .num_i (numy5_reg),
        .den_i (den5_reg),
        .quo_o (qy)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= sb5_reg;
            for (int k = 1; k < QW; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    // ---- stage 6: signed fixed point and integer rounding
    logic [EW-1:0]        qxe, qye, imx, imy;
    logic                 negx, negy;
    logic signed [EW-1:0] fx6_reg, fy6_reg, ix6_reg, iy6_reg;
    logic [SBW-1:0]       sb6_reg;

    always_comb begin
        negx = sb_reg[QW-1][1];
        negy = sb_reg[QW-1][0];
        qxe  = EW'(qx);
        qye  = EW'(qy);
        imx  = (qxe + HALF) >> F;
        imy  = (qye + HALF) >> F;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fx6_reg <= negx ? -$signed(qxe) : $signed(qxe);
            fy6_reg <= negy ? -$signed(qye) : $signed(qye);
            ix6_reg <= negx ? -$signed(imx) : $signed(imx);
            iy6_reg <= negy ? -$signed(imy) : $signed(imy);
            sb6_reg <= sb_reg[QW-1];
        end
    end

    // ---- stage 7: box tests and result word
    function automatic logic in_box(logic signed [EW-1:0] px, logic signed [EW-1:0] py,
                                    logic signed [EW-1:0] qx_i, logic signed [EW-1:0] qy_i,
                                    logic signed [EW-1:0] rx, logic signed [EW-1:0] ry);
        logic signed [EW-1:0] lx, hx, ly, hy;
        lx = (px < rx) ? px : rx;
        hx = (px < rx) ? rx : px;
        ly = (py < ry) ? py : ry;
        hy = (py < ry) ? ry : py;
        return (qx_i >= lx) && (qx_i <= hx) && (qy_i >= ly) && (qy_i <= hy);
    endfunction

    function automatic logic [siu_pkg::OUT_W-1:0] pt_fix(logic signed [EW-1:0] v);
        logic signed [63:0] w;
        w = 64'(v) << F;
        return w[siu_pkg::OUT_W-1:0];
    endfunction

    logic [CW-1:0]        crd6;
    logic [5:0]           flg6;
    logic signed [EW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic signed [63:0]   fxw, fyw;
    logic                      m_hit_next;
    siu_pkg::hit_case_t        m_hit_case_next;
    logic [siu_pkg::OUT_W-1:0] m_cross_x_next, m_cross_y_next;

    logic                      m_hit_reg;
    siu_pkg::hit_case_t        m_hit_case_reg;
    logic [siu_pkg::OUT_W-1:0] m_cross_x_reg, m_cross_y_reg;

    always_comb begin
        crd6 = sb6_reg[SBW-1:8];
        flg6 = sb6_reg[7:2];
        ax   = EW'($signed(crd6[8*C-1 -: C]));
        ay   = EW'($signed(crd6[7*C-1 -: C]));
        bx   = EW'($signed(crd6[6*C-1 -: C]));
        by   = EW'($signed(crd6[5*C-1 -: C]));
        cx   = EW'($signed(crd6[4*C-1 -: C]));
        cy   = EW'($signed(crd6[3*C-1 -: C]));
        dx   = EW'($signed(crd6[2*C-1 -: C]));
        dy   = EW'($signed(crd6[C-1 -: C]));
        fxw  = 64'(fx6_reg);
        fyw  = 64'(fy6_reg);
        m_hit_next      = 1'b0;
        m_hit_case_next = siu_pkg::HC_NONE;
        m_cross_x_next  = '0;
        m_cross_y_next  = '0;
        if (flg6[5]) begin
            if (!flg6[4] && in_box(ax, ay, ix6_reg, iy6_reg, bx, by)
                         && in_box(cx, cy, ix6_reg, iy6_reg, dx, dy)) begin
                m_hit_next      = 1'b1;
                m_hit_case_next = siu_pkg::HC_CROSS;
                m_cross_x_next  = fxw[siu_pkg::OUT_W-1:0];
                m_cross_y_next  = fyw[siu_pkg::OUT_W-1:0];
            end
        end else if (flg6[3] && in_box(ax, ay, cx, cy, bx, by)) begin
            m_hit_next      = 1'b1;
            m_hit_case_next = siu_pkg::HC_AT_C;
            m_cross_x_next  = pt_fix(cx);
            m_cross_y_next  = pt_fix(cy);
        end else if (flg6[2] && in_box(ax, ay, dx, dy, bx, by)) begin
            m_hit_next      = 1'b1;
            m_hit_case_next = siu_pkg::HC_AT_D;
            m_cross_x_next  = pt_fix(dx);
            m_cross_y_next  = pt_fix(dy);
        end else if (flg6[1] && in_box(cx, cy, ax, ay, dx, dy)) begin
            m_hit_next      = 1'b1;
            m_hit_case_next = siu_pkg::HC_AT_A;
            m_cross_x_next  = pt_fix(ax);
            m_cross_y_next  = pt_fix(ay);
        end else if (flg6[0] && in_box(cx, cy, bx, by, dx, dy)) begin
            m_hit_next      = 1'b1;
            m_hit_case_next = siu_pkg::HC_AT_B;
            m_cross_x_next  = pt_fix(bx);
            m_cross_y_next  = pt_fix(by);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[PIPE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg      <= m_hit_next;
            m_hit_case_reg <= m_hit_case_next;
            m_cross_x_reg  <= m_cross_x_next;
            m_cross_y_reg  <= m_cross_y_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = m_hit_reg;
    assign m_hit_case = m_hit_case_reg;
    assign m_cross_x  = m_cross_x_reg;
    assign m_cross_y  = m_cross_y_reg;

    // ---- checks
    a_hit_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit == (m_hit_case != siu_pkg::HC_NONE)))
        else $error("hit flag disagrees with hit case");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_cross_x == '0 && m_cross_y == '0))
        else $error("miss word carries a nonzero point");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted word not in first stage");

endmodule

// ===== hdl/siu_div_lane.sv =====
// ============================================================================
// siu_div_lane
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module siu_div_lane #(
    parameter int NW = 70,
    parameter int DW = 34,
    parameter int QW = 34
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num_i,
    input  logic [DW-1:0] den_i,
    output logic [QW-1:0] quo_o
);

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_reg;
        logic [QW-1:0] low_reg;
        logic [QW-1:0] quo_reg;
        logic [DW-1:0] den_reg;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0) begin : g_first
            // high part of the numerator is below the divisor by construction
            assign rem_in = num_i[QW +: DW];
            assign low_in = num_i[QW-1:0];
            assign quo_in = '0;
            assign den_in = den_i;
        end else begin : g_next
            assign rem_in = g_stage[k-1].rem_reg;
            assign low_in = g_stage[k-1].low_reg;
            assign quo_in = g_stage[k-1].quo_reg;
            assign den_in = g_stage[k-1].den_reg;
        end

        always_comb begin
            trial    = {rem_in, low_in[QW-1]};
            ge       = (trial >= {1'b0, den_in});
            rem_next = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
            quo_next = {quo_in[QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg <= rem_next;
                low_reg <= {low_in[QW-2:0], 1'b0};
                quo_reg <= quo_next;
                den_reg <= den_in;
            end
        end
    end

    assign quo_o = g_stage[QW-1].quo_reg;

endmodule
